/* hdl/mwcrg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwcrg_pkg: shared types and constants of the MWC random generator
// Holds the command codes, the generator constants, the queue entry format
// and the status group that the back end reports to the top level.
// ----------------------------------------------------------------------------
package mwcrg_pkg;

   // Command codes carried on the request tuser.
   localparam logic [1:0] CMD_SEED   = 2'd0;
   localparam logic [1:0] CMD_DRAW   = 2'd1;
   localparam logic [1:0] CMD_RANGED = 2'd2;

   // Generator constants.
   localparam logic [15:0] MUL_Z      = 16'd36969;
   localparam logic [15:0] MUL_W      = 16'd18000;
   localparam int          HALF_SHIFT = 16;

   // Reset values of the two generator words.
   localparam logic [31:0] WORD_W_RESET = 32'd1;
   localparam logic [31:0] WORD_Z_RESET = 32'd2;

   // Depth of the queue between front and back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // What the back end has to do with an item.
   typedef enum logic [2:0] {
      KIND_ZERO   = 3'd0,  // seed or unused command: all results zero
      KIND_RAW    = 3'd1,  // raw draw
      KIND_ERROR  = 3'd2,  // ranged draw with high below low
      KIND_WRAP   = 3'd3,  // ranged draw whose span wraps to zero
      KIND_MODULO = 3'd4   // ranged draw that needs the remainder
   } kind_type;

   // One queue entry.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] raw;
      logic [31:0] low;
      logic [31:0] span;
   } entry_type;

   // Back end status seen by the top level.
   typedef struct packed {
      logic dividing;
      logic holding;
   } back_status_type;

endpackage
`default_nettype wire

/* hdl/mwcrg_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwcrg_front: command front end
// Accepts request items, owns the two generator words, advances them on a
// draw and classifies each item into a queue entry for the back end.
// ----------------------------------------------------------------------------
module mwcrg_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire  [1:0]              cmd,
   input  wire  [31:0]             seed_w,
   input  wire  [31:0]             seed_z,
   input  wire  [31:0]             range_low,
   input  wire  [31:0]             range_high,
   input  wire                     queue_full,
   output logic                    push,
   output mwcrg_pkg::entry_type    push_entry
);

   logic [31:0] word_w_ff, word_w_in;
   logic [31:0] word_z_ff, word_z_in;
   logic [31:0] z_next, w_next, raw;
   logic [31:0] span;
   logic        inverted;
   logic        accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept;

   // One multiply-with-carry step on each half; the full 32-bit product is kept.
   assign z_next = {16'b0, mwcrg_pkg::MUL_Z} * {16'b0, word_z_ff[15:0]}
                 + {16'b0, word_z_ff[31:16]};
   assign w_next = {16'b0, mwcrg_pkg::MUL_W} * {16'b0, word_w_ff[15:0]}
                 + {16'b0, word_w_ff[31:16]};
   assign raw    = {z_next[15:0], 16'b0} + w_next;

   // Range checks for a ranged draw.
   assign inverted = $signed(range_high) < $signed(range_low);
   assign span     = range_high - range_low + 32'd1;

   // Next state of the generator words and the entry to push.
   always_comb begin
      word_w_in       = word_w_ff;
      word_z_in       = word_z_ff;
      push_entry.kind = mwcrg_pkg::KIND_ZERO;
      push_entry.raw  = raw;
      push_entry.low  = range_low;
      push_entry.span = span;
      unique case (cmd)
         mwcrg_pkg::CMD_SEED: begin
            word_w_in = (seed_w == 32'd0) ? 32'd1 : seed_w;
            word_z_in = (seed_z == 32'd0) ? 32'd1 : seed_z;
         end
         mwcrg_pkg::CMD_DRAW: begin
            word_w_in       = w_next;
            word_z_in       = z_next;
            push_entry.kind = mwcrg_pkg::KIND_RAW;
         end
         mwcrg_pkg::CMD_RANGED: begin
            word_w_in = w_next;
            word_z_in = z_next;
            if (inverted) begin
               push_entry.kind = mwcrg_pkg::KIND_ERROR;
            end else if (span == 32'd0) begin
               push_entry.kind = mwcrg_pkg::KIND_WRAP;
            end else begin
               push_entry.kind = mwcrg_pkg::KIND_MODULO;
            end
         end
         default: begin
            // Unused command leaves the state alone and gives zeros.
            push_entry.kind = mwcrg_pkg::KIND_ZERO;
         end
      endcase
   end

   // Generator words change only when an item is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_w_ff <= mwcrg_pkg::WORD_W_RESET;
         word_z_ff <= mwcrg_pkg::WORD_Z_RESET;
      end else if (accept) begin
         word_w_ff <= word_w_in;
         word_z_ff <= word_z_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/mwcrg_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwcrg_queue: short FIFO between front and back end
// Holds classified items so that the front can take requests while the
// back end is busy with a remainder or a result waits to be taken.
// ----------------------------------------------------------------------------
module mwcrg_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  mwcrg_pkg::entry_type    push_entry,
   input  wire                     pop,
   output mwcrg_pkg::entry_type    head_entry,
   output logic                    full,
   output logic                    empty
);

   localparam int PTR_W = mwcrg_pkg::QUEUE_PTR_W;
   localparam int CNT_W = mwcrg_pkg::QUEUE_CNT_W;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(mwcrg_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(mwcrg_pkg::QUEUE_DEPTH);

   mwcrg_pkg::entry_type entries_ff [mwcrg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign empty      = (count_ff == '0);
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = entries_ff[rd_ptr_ff];

   // Pointer and count updates, pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

/* hdl/mwcrg_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwcrg_back: result back end
// Takes queue entries one at a time, runs a restoring remainder unit one bit
// per cycle for ranged draws that need it and holds the result until taken.
// ----------------------------------------------------------------------------
module mwcrg_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          queue_empty,
   input  mwcrg_pkg::entry_type         head_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [31:0]                  raw_value,
   output logic [31:0]                  ranged_value,
   output logic                         range_error,
   output mwcrg_pkg::back_status_type   status
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_HOLD   = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dividend_ff, dividend_in;
   logic [31:0] span_ff, span_in;
   logic [31:0] low_ff, low_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] raw_ff, raw_in;
   logic [31:0] ranged_ff, ranged_in;
   logic        error_ff, error_in;
   logic [32:0] trial, diff;
   logic        fits;

   assign rsp_valid       = (state_ff == ST_HOLD);
   assign raw_value       = raw_ff;
   assign ranged_value    = ranged_ff;
   assign range_error     = error_ff;
   assign status.dividing = (state_ff == ST_DIVIDE);
   assign status.holding  = (state_ff == ST_HOLD);
   assign pop             = (state_ff == ST_IDLE) && !queue_empty;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign trial = {rem_ff, dividend_ff[31]};
   assign diff  = trial - {1'b0, span_ff};
   assign fits  = (trial >= {1'b0, span_ff});

   always_comb begin
      state_in    = state_ff;
      rem_in      = rem_ff;
      dividend_in = dividend_ff;
      span_in     = span_ff;
      low_in      = low_ff;
      count_in    = count_ff;
      raw_in      = raw_ff;
      ranged_in   = ranged_ff;
      error_in    = error_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               raw_in      = head_entry.raw;
               ranged_in   = 32'd0;
               error_in    = 1'b0;
               rem_in      = 32'd0;
               dividend_in = head_entry.raw;
               span_in     = head_entry.span;
               low_in      = head_entry.low;
               count_in    = 5'd0;
               state_in    = ST_HOLD;
               unique case (head_entry.kind)
                  mwcrg_pkg::KIND_ZERO: begin
                     raw_in = 32'd0;
                  end
                  mwcrg_pkg::KIND_RAW: begin
                  end
                  mwcrg_pkg::KIND_ERROR: begin
                     error_in = 1'b1;
                  end
                  mwcrg_pkg::KIND_WRAP: begin
                     ranged_in = head_entry.raw + head_entry.low;
                  end
                  mwcrg_pkg::KIND_MODULO: begin
                     state_in = ST_DIVIDE;
                  end
                  default: begin
                     raw_in = 32'd0;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            rem_in      = fits ? diff[31:0] : trial[31:0];
            dividend_in = {dividend_ff[30:0], 1'b0};
            count_in    = count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               ranged_in = (fits ? diff[31:0] : trial[31:0]) + low_ff;
               state_in  = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 5'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Datapath and result registers.
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      dividend_ff <= dividend_in;
      span_ff     <= span_in;
      low_ff      <= low_in;
      raw_ff      <= raw_in;
      ranged_ff   <= ranged_in;
      error_ff    <= error_in;
   end

endmodule
`default_nettype wire

/* hdl/mwc_random_generator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwc_random_generator_unit: multiply-with-carry random number generator
// Two 32-bit MWC words with seed, raw draw and ranged draw commands.
// ----------------------------------------------------------------------------
// Each request item is a command; each gives exactly one response item, in
// order. A seed, a raw draw or a ranged draw that needs no remainder passes
// through the queue into the back end's result register, where its response
// waits to be taken. A ranged draw that needs a remainder is loaded into the
// back end, runs 32 steps of the one-bit-per-cycle restoring remainder unit
// and then presents its result. That unit sets the sustained rate. The front
// end advances the generator when a draw request is accepted and a two-entry
// queue lets it keep taking requests while the back end works.
// ----------------------------------------------------------------------------
module mwc_random_generator_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // req_tdata: seed_w[31:0], seed_z[63:32], range_low[95:64], range_high[127:96]
   input  wire  [127:0] req_tdata,
   // req_tuser: cmd[1:0]
   input  wire  [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // rsp_tdata: raw_value[31:0], ranged_value[63:32]
   output logic [63:0]  rsp_tdata,
   // rsp_tuser: range_error[0]
   output logic [0:0]   rsp_tuser
);

   logic                           push, pop;
   logic                           queue_full, queue_empty;
   mwcrg_pkg::entry_type           push_entry, head_entry;
   mwcrg_pkg::back_status_type     back_status;
   logic [31:0]                    raw_value, ranged_value;
   logic                           range_error;

   // Front end: accept and classify.
   mwcrg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .cmd        (req_tuser),
      .seed_w     (req_tdata[31:0]),
      .seed_z     (req_tdata[63:32]),
      .range_low  (req_tdata[95:64]),
      .range_high (req_tdata[127:96]),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue between the two halves.
   mwcrg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   // Back end: remainder and result register.
   mwcrg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (queue_empty),
      .head_entry   (head_entry),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .raw_value    (raw_value),
      .ranged_value (ranged_value),
      .range_error  (range_error),
      .status       (back_status)
   );

   assign rsp_tdata = {ranged_value, raw_value};
   assign rsp_tuser = range_error;

   // No response is offered right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A flagged range error never carries a ranged value.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[63:32] == 32'd0))
      else $error("range error with nonzero ranged value");

   // While the remainder unit runs, no response is offered.
   a_divide_quiet: assert property (@(posedge clock) disable iff (reset)
      back_status.dividing |-> !rsp_tvalid)
      else $error("response valid during remainder steps");

   // The back end only pops an entry when idle and the queue holds one.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!queue_empty && !back_status.dividing && !back_status.holding))
      else $error("queue popped while back end busy");

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the multiply-with-carry random generator
// Sends seed, raw draw, ranged draw and unused commands over the request
// stream and predicts every response item from a private copy of the two
// generator words. Directed items cover the reset state, zero and extreme
// seeds, inverted, single-value and wrapping ranges. Random traffic follows
// with and without gaps on both streams.
// ----------------------------------------------------------------------------
module tb;

   // The fourth command code is not used by the block and must be ignored.
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RUN_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PRINT_LIMIT = 100;

   typedef struct {
      logic [31:0] raw_value;
      logic [31:0] ranged_value;
      logic        range_error;
   } draw_result_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   // Private copy of the generator words.
   logic [31:0] gen_w;
   logic [31:0] gen_z;

   draw_result_type pending_draws[$];
   draw_result_type oldest_draw;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              stall_left = 0;
   int              stall_pick;
   bit              gaps_on = 1'b0;

   mwc_random_generator_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Works out the response of one command and updates the generator words.
   function automatic draw_result_type predict_command(input logic [1:0] cmd,
                                                       input logic [31:0] seed_w,
                                                       input logic [31:0] seed_z,
                                                       input logic [31:0] low,
                                                       input logic [31:0] high);
      draw_result_type res;
      logic [31:0]     span;
      res = '{32'd0, 32'd0, 1'b0};
      if (cmd == mwcrg_pkg::CMD_SEED) begin
         gen_w = (seed_w == 32'd0) ? 32'd1 : seed_w;
         gen_z = (seed_z == 32'd0) ? 32'd1 : seed_z;
      end else if (cmd == mwcrg_pkg::CMD_DRAW || cmd == mwcrg_pkg::CMD_RANGED) begin
         gen_z = 32'(mwcrg_pkg::MUL_Z) * {16'd0, gen_z[15:0]}
               + (gen_z >> mwcrg_pkg::HALF_SHIFT);
         gen_w = 32'(mwcrg_pkg::MUL_W) * {16'd0, gen_w[15:0]}
               + (gen_w >> mwcrg_pkg::HALF_SHIFT);
         res.raw_value = (gen_z << mwcrg_pkg::HALF_SHIFT) + gen_w;
         if (cmd == mwcrg_pkg::CMD_RANGED) begin
            span = high - low + 32'd1;
            if ($signed(high) < $signed(low)) begin
               res.range_error = 1'b1;
            end else if (span == 32'd0) begin
               // The whole 32-bit range: the span wraps to zero.
               res.ranged_value = res.raw_value + low;
            end else begin
               res.ranged_value = res.raw_value % span + low;
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch in %s at %0t ns: got %h, want %h", what, $realtime, got, want);
   endtask

   // Sends one command item after a random gap and records its prediction.
   task automatic send_command(input logic [1:0] cmd, input logic [31:0] seed_w,
                               input logic [31:0] seed_z, input logic [31:0] low,
                               input logic [31:0] high);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {high, low, seed_z, seed_w};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_draws.push_back(predict_command(cmd, seed_w, seed_z, low, high));
   endtask

   // Response side stalls.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         stall_pick = pick_gap();
         rsp_tready <= (stall_pick == 0);
         if (stall_pick != 0) stall_left <= stall_pick - 1;
      end
   end

   // Compares each response item with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_draws.size() == 0) begin
            report_mismatch("unrequested item", rsp_tdata[31:0], 32'd0);
         end else begin
            oldest_draw = pending_draws.pop_front();
            if (rsp_tdata[31:0] !== oldest_draw.raw_value)
               report_mismatch("raw_value", rsp_tdata[31:0], oldest_draw.raw_value);
            if (rsp_tdata[63:32] !== oldest_draw.ranged_value)
               report_mismatch("ranged_value", rsp_tdata[63:32], oldest_draw.ranged_value);
            if (rsp_tuser[0] !== oldest_draw.range_error)
               report_mismatch("range_error", {31'd0, rsp_tuser[0]},
                               {31'd0, oldest_draw.range_error});
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Draws straight from the reset words.
   task automatic test_reset_sequence();
      send_command(mwcrg_pkg::CMD_DRAW, $urandom, $urandom, $urandom, $urandom);
      send_command(mwcrg_pkg::CMD_DRAW, $urandom, $urandom, $urandom, $urandom);
      send_command(mwcrg_pkg::CMD_RANGED, $urandom, $urandom, 32'd0, 32'd99);
      send_command(mwcrg_pkg::CMD_DRAW, $urandom, $urandom, $urandom, $urandom);
   endtask

   // Zero and extreme seeds, and the unused command.
   task automatic test_seeding();
      send_command(mwcrg_pkg::CMD_SEED, 32'd0, 32'd0, $urandom, $urandom);
      send_command(mwcrg_pkg::CMD_DRAW, $urandom, $urandom, $urandom, $urandom);
      send_command(mwcrg_pkg::CMD_SEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, $urandom);
      send_command(mwcrg_pkg::CMD_DRAW, $urandom, $urandom, $urandom, $urandom);
      send_command(mwcrg_pkg::CMD_SEED, 32'h0000_FFFF, 32'hFFFF_0000, $urandom, $urandom);
      send_command(mwcrg_pkg::CMD_DRAW, $urandom, $urandom, $urandom, $urandom);
      send_command(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
      send_command(CMD_UNUSED, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_command(mwcrg_pkg::CMD_DRAW, $urandom, $urandom, $urandom, $urandom);
   endtask

   // Bounds of the ranged draw.
   task automatic test_ranged_bounds();
      send_command(mwcrg_pkg::CMD_RANGED, $urandom, $urandom, 32'd5, 32'd4);
      send_command(mwcrg_pkg::CMD_RANGED, $urandom, $urandom, 32'h7FFF_FFFF, 32'h8000_0000);
      send_command(mwcrg_pkg::CMD_RANGED, $urandom, $urandom, 32'h8000_0000, 32'h7FFF_FFFF);
      send_command(mwcrg_pkg::CMD_RANGED, $urandom, $urandom, 32'h8000_0000, 32'h8000_0000);
      send_command(mwcrg_pkg::CMD_RANGED, $urandom, $urandom, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_command(mwcrg_pkg::CMD_RANGED, $urandom, $urandom, 32'h8000_0000, 32'h7FFF_FFFE);
      send_command(mwcrg_pkg::CMD_RANGED, $urandom, $urandom, 32'h8000_0001, 32'h7FFF_FFFF);
      send_command(mwcrg_pkg::CMD_RANGED, $urandom, $urandom, 32'hFFFF_FFFF, 32'd0);
      send_command(mwcrg_pkg::CMD_RANGED, $urandom, $urandom, 32'hFFFF_FF00, 32'h0000_00FF);
   endtask

   // Random command mix; the first stretch runs without any gaps.
   task automatic test_random_traffic(input int count);
      int          pick;
      logic [1:0]  cmd;
      logic [31:0] seed_w;
      logic [31:0] seed_z;
      logic [31:0] low;
      logic [31:0] high;
      for (int i = 0; i < count; i++) begin
         gaps_on = (i >= 250);
         pick = $urandom_range(0, 99);
         seed_w = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
         seed_z = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
         low = $urandom;
         high = $urandom;
         if (pick < 4) cmd = mwcrg_pkg::CMD_SEED;
         else if (pick < 6) cmd = CMD_UNUSED;
         else if (pick < 50) cmd = mwcrg_pkg::CMD_DRAW;
         else cmd = mwcrg_pkg::CMD_RANGED;
         // Shape the bounds so that every kind of range comes up often.
         case ($urandom_range(0, 9))
            0, 1, 2, 3: high = low + $urandom_range(0, 255);
            6: high = low + (32'd1 << $urandom_range(0, 31)) - 32'd1;
            7: begin
               low = 32'h8000_0000;
               high = 32'h7FFF_FFFF;
            end
            8: high = low;
            9: begin
               low = 32'h8000_0000 + $urandom_range(0, 3);
               high = 32'h7FFF_FFFF - $urandom_range(0, 3);
            end
            default: ;
         endcase
         send_command(cmd, seed_w, seed_z, low, high);
      end
   endtask

   // Waits for every predicted item, lets the block settle and reports.
   task automatic finish_run();
      req_tvalid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= mwcrg_pkg::CMD_SEED;
      gen_w = mwcrg_pkg::WORD_W_RESET;
      gen_z = mwcrg_pkg::WORD_Z_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_sequence();
      test_seeding();
      test_ranged_bounds();
      test_random_traffic(1650);
      finish_run();
   end

endmodule
